### src/rar_pkg.sv
// shared constants, types and state encodings for the rational reduce unit
`default_nettype none

package rar_pkg;

    // operand and field widths
    localparam int OPERAND_WIDTH = 16;
    localparam int FIELD_W       = 16;
    localparam int CMD_W         = 2;
    localparam int RES_W         = 34;

    // raw cross-product width and magnitude width
    localparam int PROD_W = 2 * OPERAND_WIDTH;
    localparam int RAW_W  = PROD_W + 1;
    localparam int MAG_W  = RAW_W;

    // shift count of the binary gcd and bit counter of the divider
    localparam int SHIFT_W = $clog2(MAG_W);
    localparam int CNT_W   = $clog2(MAG_W);

    // operation codes
    typedef enum logic [CMD_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MAG,
        ST_GCD,
        ST_DIV,
        ST_OUT
    } state_t;

    // multiply step index
    typedef logic [1:0] step_t;

    localparam step_t STEP_TERM0 = 2'd0;
    localparam step_t STEP_TERM1 = 2'd1;
    localparam step_t STEP_DEN   = 2'd2;

    // unit handshake between the sequencer and a shared unit
    typedef struct packed {
        logic start;
    } unit_ctrl_t;

    typedef struct packed {
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

### src/rar_if.sv
// valid/ready channel interfaces for operand beats and result beats
`default_nettype none

interface rar_in_if;
    import rar_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic signed [FIELD_W-1:0]  lhs_num;
    logic signed [FIELD_W-1:0]  lhs_den;
    logic signed [FIELD_W-1:0]  rhs_num;
    logic signed [FIELD_W-1:0]  rhs_den;

    modport source (output valid, cmd, lhs_num, lhs_den, rhs_num, rhs_den, input ready);
    modport sink   (input valid, cmd, lhs_num, lhs_den, rhs_num, rhs_den, output ready);
endinterface

interface rar_out_if;
    import rar_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [RES_W-1:0]  res_num;
    logic signed [RES_W-1:0]  res_den;

    modport source (output valid, res_num, res_den, input ready);
    modport sink   (input valid, res_num, res_den, output ready);
endinterface

`default_nettype wire

### src/rational_arith_reduce_unit.sv
// rational add/sub/mul/div of two fractions with gcd reduction of the result
//
// item carries one operation beat: cmd and the two fractions lhs and rhs.
// result carries one beat per item: the reduced numerator and denominator,
// with the sign left where the cross products put it (the denominator may be
// negative or zero; 0/0 stays 0/0).
// item.ready is high only while the sequencer is idle; one item is in work
// at a time. The cross products come from one shared 16x16 multiplier, the
// reduction from a binary gcd unit (one shift or subtract step per cycle on
// 33-bit magnitudes) and a two-lane restoring divider (skipped when the gcd
// is 0 or 1). The time from accepted item to result valid depends on the
// number of gcd steps and on whether the divider runs.
// The result sits in an output register; a new item is taken while it waits,
// and the sequencer holds its finished result only if that register is still
// full when the next one is ready. Reset empties the output register and
// returns the sequencer to idle.
`default_nettype none

module rational_arith_reduce_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    rar_in_if.sink    item,
    rar_out_if.source result
);
    import rar_pkg::*;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    op_t                              cmd_reg;
    logic signed [OPERAND_WIDTH-1:0]  ln_reg, ld_reg, rn_reg, rd_reg;
    logic signed [RAW_W-1:0]          num_reg, den_reg;
    logic signed [OPERAND_WIDTH-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]         prod;
    logic signed [RAW_W-1:0]          prod_ext;
    logic [MAG_W-1:0]                 num_mag, den_mag;
    logic [MAG_W-1:0]                 g;
    logic [MAG_W-1:0]                 quot_num, quot_den;
    logic                             g_big;

    logic                             out_valid_reg, out_valid_next;
    logic signed [RES_W-1:0]          res_num_reg, res_den_reg;

    logic       take_item;
    logic       out_load;
    unit_ctrl_t gcd_ctrl, div_ctrl;
    unit_stat_t gcd_stat, div_stat;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = rd_reg;
        mul_b = ld_reg;
        case (step_reg)
            STEP_TERM0:
            begin
                case (cmd_reg)
                    OP_ADD:  begin mul_a = rn_reg; mul_b = ld_reg; end
                    OP_SUB:  begin mul_a = rd_reg; mul_b = ln_reg; end
                    OP_MUL:  begin mul_a = rn_reg; mul_b = ln_reg; end
                    default: begin mul_a = rd_reg; mul_b = ln_reg; end
                endcase
            end
            STEP_TERM1:
            begin
                case (cmd_reg)
                    OP_ADD:  begin mul_a = rd_reg; mul_b = ln_reg; end
                    default: begin mul_a = ld_reg; mul_b = rn_reg; end
                endcase
            end
            default:
            begin
                if (cmd_reg == OP_DIV)
                begin
                    mul_a = ld_reg;
                    mul_b = rn_reg;
                end
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = RAW_W'(prod);

    // magnitudes of the raw pair
    assign num_mag = num_reg[RAW_W-1] ? MAG_W'(-num_reg) : MAG_W'(num_reg);
    assign den_mag = den_reg[RAW_W-1] ? MAG_W'(-den_reg) : MAG_W'(den_reg);
    assign g_big   = (g > MAG_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (step_reg == STEP_DEN)
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                state_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (gcd_stat.done)
                begin
                    state_next = g_big ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        take_item      = 1'b0;
        gcd_ctrl.start = 1'b0;
        div_ctrl.start = 1'b0;
        out_load       = 1'b0;
        step_next      = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                take_item = item.valid;
                step_next = STEP_TERM0;
            end
            ST_MUL:
            begin
                step_next = step_reg + step_t'(1);
            end
            ST_MAG:
            begin
                gcd_ctrl.start = 1'b1;
            end
            ST_GCD:
            begin
                div_ctrl.start = gcd_stat.done && g_big;
            end
            ST_OUT:
            begin
                out_load = !out_valid_reg || result.ready;
            end
            default:
            begin
                step_next = STEP_TERM0;
            end
        endcase
    end

    assign item.ready = (state_reg == ST_IDLE);

    // output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_TERM0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // operand capture
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            cmd_reg <= op_t'(item.cmd);
            ln_reg  <= item.lhs_num[OPERAND_WIDTH-1:0];
            ld_reg  <= item.lhs_den[OPERAND_WIDTH-1:0];
            rn_reg  <= item.rhs_num[OPERAND_WIDTH-1:0];
            rd_reg  <= item.rhs_den[OPERAND_WIDTH-1:0];
        end
    end

    // raw pair accumulation, then signed quotients
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            case (step_reg)
                STEP_TERM0:
                begin
                    num_reg <= prod_ext;
                end
                STEP_TERM1:
                begin
                    if (cmd_reg == OP_ADD)
                    begin
                        num_reg <= num_reg + prod_ext;
                    end
                    else if (cmd_reg == OP_SUB)
                    begin
                        num_reg <= num_reg - prod_ext;
                    end
                end
                default:
                begin
                    den_reg <= prod_ext;
                end
            endcase
        end
        else if (state_reg == ST_DIV && div_stat.done)
        begin
            num_reg <= num_reg[RAW_W-1] ? -RAW_W'(quot_num) : RAW_W'(quot_num);
            den_reg <= den_reg[RAW_W-1] ? -RAW_W'(quot_den) : RAW_W'(quot_den);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_num_reg <= RES_W'(num_reg);
            res_den_reg <= RES_W'(den_reg);
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.res_num = res_num_reg;
    assign result.res_den = res_den_reg;

    rar_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (gcd_ctrl),
        .a     (num_mag),
        .b     (den_mag),
        .stat  (gcd_stat),
        .g     (g)
    );

    rar_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .divisor   (g),
        .dividend0 (num_mag),
        .dividend1 (den_mag),
        .stat      (div_stat),
        .quot0     (quot_num),
        .quot1     (quot_den)
    );

endmodule

`default_nettype wire

### src/rar_gcd.sv
// binary gcd unit: one shift or subtract-and-shift step per cycle
`default_nettype none

module rar_gcd (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire rar_pkg::unit_ctrl_t      ctrl,
    input  wire logic [rar_pkg::MAG_W-1:0] a,
    input  wire logic [rar_pkg::MAG_W-1:0] b,
    output rar_pkg::unit_stat_t           stat,
    output logic [rar_pkg::MAG_W-1:0]     g
);
    import rar_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [MAG_W-1:0]   a_reg, a_next;
    logic [MAG_W-1:0]   b_reg, b_next;
    logic [SHIFT_W-1:0] k_reg, k_next;
    logic [MAG_W-1:0]   g_reg, g_next;

    // one step of the binary gcd
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            k_next    = '0;
        end
        else if (busy_reg)
        begin
            if (a_reg == '0 || b_reg == '0)
            begin
                // gcd of x and 0 is x, restore the common power of two
                g_next    = (a_reg | b_reg) << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + SHIFT_W'(1);
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_next = (a_reg - b_reg) >> 1;
            end
            else
            begin
                b_next = (b_reg - a_reg) >> 1;
            end
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign stat.done = done_reg;
    assign g         = g_reg;

endmodule

`default_nettype wire

### src/rar_div.sv
// restoring divider: two dividends over one common divisor, one bit per cycle
`default_nettype none

module rar_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire rar_pkg::unit_ctrl_t       ctrl,
    input  wire logic [rar_pkg::MAG_W-1:0] divisor,
    input  wire logic [rar_pkg::MAG_W-1:0] dividend0,
    input  wire logic [rar_pkg::MAG_W-1:0] dividend1,
    output rar_pkg::unit_stat_t            stat,
    output logic [rar_pkg::MAG_W-1:0]      quot0,
    output logic [rar_pkg::MAG_W-1:0]      quot1
);
    import rar_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] d_reg, d_next;
    logic [MAG_W-1:0] rem0_reg, rem0_next;
    logic [MAG_W-1:0] rem1_reg, rem1_next;
    logic [MAG_W-1:0] q0_reg, q0_next;
    logic [MAG_W-1:0] q1_reg, q1_next;
    logic [MAG_W:0]   trial0, trial1;

    // partial remainders with the next dividend bit shifted in
    assign trial0 = {rem0_reg, q0_reg[MAG_W-1]};
    assign trial1 = {rem1_reg, q1_reg[MAG_W-1]};

    // one quotient bit per lane
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        d_next    = d_reg;
        rem0_next = rem0_reg;
        rem1_next = rem1_reg;
        q0_next   = q0_reg;
        q1_next   = q1_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W - 1);
            d_next    = divisor;
            rem0_next = '0;
            rem1_next = '0;
            q0_next   = dividend0;
            q1_next   = dividend1;
        end
        else if (busy_reg)
        begin
            if (trial0 >= {1'b0, d_reg})
            begin
                rem0_next = MAG_W'(trial0 - {1'b0, d_reg});
                q0_next   = {q0_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem0_next = trial0[MAG_W-1:0];
                q0_next   = {q0_reg[MAG_W-2:0], 1'b0};
            end
            if (trial1 >= {1'b0, d_reg})
            begin
                rem1_next = MAG_W'(trial1 - {1'b0, d_reg});
                q1_next   = {q1_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem1_next = trial1[MAG_W-1:0];
                q1_next   = {q1_reg[MAG_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        d_reg    <= d_next;
        rem0_reg <= rem0_next;
        rem1_reg <= rem1_next;
        q0_reg   <= q0_next;
        q1_reg   <= q1_next;
    end

    assign stat.done = done_reg;
    assign quot0     = q0_reg;
    assign quot1     = q1_reg;

endmodule

`default_nettype wire
